// File: hdl/yuyv_nearest_neighbor_scaler_defines.svh
// Assertion macros for the YUYV nearest-neighbor scaler.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef YUYV_NEAREST_NEIGHBOR_SCALER_DEFINES_SVH
`define YUYV_NEAREST_NEIGHBOR_SCALER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define YYNS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define YYNS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/yyns_pkg.sv
// Shared constants, types and helper functions of the YUYV nearest-neighbor scaler.
// No dependencies; used by the channel interfaces, the top level and the testbench.
`default_nettype none

package yyns_pkg;

   localparam int MAX_PAIRS = 2048;
   localparam int MAX_ROWS  = 4096;

   localparam int PIX_WIDTH     = 32;
   localparam int WIDTH_WIDTH   = 12;   // source_width_pairs, dest_width_pairs
   localparam int HEIGHT_WIDTH  = 13;   // source_height, dest_height
   localparam int COL_WIDTH     = $clog2(MAX_PAIRS);
   localparam int ROW_WIDTH     = $clog2(MAX_ROWS);
   localparam int ADDR_WIDTH    = COL_WIDTH + 1;
   localparam int LINE_DEPTH    = 2 * MAX_PAIRS;
   localparam int STATUS_WIDTH  = 3;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int CSR_DAT_WIDTH = HEIGHT_WIDTH;

   // divider operands are carried at the height width
   localparam int DIV_WIDTH     = HEIGHT_WIDTH;

   localparam logic [STATUS_WIDTH-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_NOT_LOADED  = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_OVERWRITTEN = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_REFUSED     = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_BAD_CONFIG  = 3'd4;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DST_HEIGHT = 3'd3;

   localparam logic [WIDTH_WIDTH-1:0]  RST_SRC_WIDTH  = 12'd960;
   localparam logic [HEIGHT_WIDTH-1:0] RST_SRC_HEIGHT = 13'd1080;
   localparam logic [WIDTH_WIDTH-1:0]  RST_DST_WIDTH  = 12'd1920;
   localparam logic [HEIGHT_WIDTH-1:0] RST_DST_HEIGHT = 13'd2160;

   localparam logic [0:0] ACT_LOAD = 1'b0;
   localparam logic [0:0] ACT_EMIT = 1'b1;

   typedef struct packed {
      logic [DIV_WIDTH-1:0] rem;
      logic                 qbit;
   } div_step_type;

   // one restoring division step: shift in the next dividend bit, subtract if it fits
   function automatic div_step_type div_step(input logic [DIV_WIDTH-1:0] rem,
                                             input logic                 in_bit,
                                             input logic [DIV_WIDTH-1:0] divisor);
      logic [DIV_WIDTH:0] trial;
      logic [DIV_WIDTH:0] diff;
      div_step_type       res;
      trial = {rem, in_bit};
      diff  = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
         res.rem  = diff[DIV_WIDTH-1:0];
         res.qbit = 1'b1;
      end else begin
         res.rem  = trial[DIV_WIDTH-1:0];
         res.qbit = 1'b0;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: hdl/yyns_if.sv
// Valid/ready channel interfaces of the YUYV nearest-neighbor scaler.
// Depends on yyns_pkg for field widths.
`default_nettype none

interface yyns_req_if;
   logic                             valid;
   logic                             ready;
   logic                             action;
   logic [yyns_pkg::PIX_WIDTH-1:0]   pixel_pair_in;

   modport source (output valid, action, pixel_pair_in, input ready);
   modport sink   (input valid, action, pixel_pair_in, output ready);
endinterface

interface yyns_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [yyns_pkg::PIX_WIDTH-1:0]    pixel_pair_out;
   logic                              row_end;
   logic                              frame_end;
   logic [yyns_pkg::STATUS_WIDTH-1:0] status;

   modport source (output valid, pixel_pair_out, row_end, frame_end, status, input ready);
   modport sink   (input valid, pixel_pair_out, row_end, frame_end, status, output ready);
endinterface

`default_nettype wire

// File: hdl/yuyv_nearest_neighbor_scaler.sv
// Nearest-neighbor scaler for packed YUYV 4:2:2 video, one macropixel per word.
// A load word (action 0) writes the next source macropixel into one of two line buffers
// (source row parity picks the buffer); an emit word (action 1) returns the next
// destination macropixel with row_end and frame_end, or a status code when the needed
// row is not there; bad sizes and loads past the last source row get a status code too.
// Every request word yields exactly one response word. The line buffer is a single
// 4096 x 32 synchronous memory with a registered read; ready stays low while the read
// of a good emit is pending. After reset and after every configuration write ready is
// low while two 13-step restoring dividers work out the per-row and per-column source
// step (quotient and remainder); source row and column then advance by add-and-compare
// steppers. The line store is not cleared. Depends on yyns_pkg, yyns_if, the defines header.
`default_nettype none
`include "yuyv_nearest_neighbor_scaler_defines.svh"

module yuyv_nearest_neighbor_scaler (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   yyns_req_if.sink                                  req_chan,
   yyns_rsp_if.source                                rsp_chan,
   input  wire logic                                 csr_write_enable,
   input  wire logic [yyns_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [yyns_pkg::CSR_DAT_WIDTH-1:0]   csr_write_data
);

   localparam int WW = yyns_pkg::WIDTH_WIDTH;
   localparam int HW = yyns_pkg::HEIGHT_WIDTH;
   localparam int CW = yyns_pkg::COL_WIDTH;
   localparam int RW = yyns_pkg::ROW_WIDTH;
   localparam int DW = yyns_pkg::DIV_WIDTH;
   localparam int AW = yyns_pkg::ADDR_WIDTH;
   localparam int PW = yyns_pkg::PIX_WIDTH;
   localparam int SW = yyns_pkg::STATUS_WIDTH;
   localparam int DIV_STEPS = DW;
   localparam int CNT_WIDTH = $clog2(DIV_STEPS);

   localparam logic [1:0] S_SETUP = 2'd0;
   localparam logic [1:0] S_DIV   = 2'd1;
   localparam logic [1:0] S_RUN   = 2'd2;

   // configuration
   logic [WW-1:0] src_w_ff, src_w_in, dst_w_ff, dst_w_in;
   logic [HW-1:0] src_h_ff, src_h_in, dst_h_ff, dst_h_in;

   // control
   logic [1:0]           state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;

   // dividers: rows (src_h / dst_h) and columns (src_w / dst_w)
   logic [DW-1:0] hdvd_ff, hdvd_in, hrem_ff, hrem_in, hquo_ff, hquo_in;
   logic [DW-1:0] wdvd_ff, wdvd_in, wrem_ff, wrem_in, wquo_ff, wquo_in;
   yyns_pkg::div_step_type hstep, wstep;

   // positions
   logic [CW-1:0] load_col_ff, load_col_in;
   logic [HW-1:0] rows_done_ff, rows_done_in;
   logic [CW-1:0] emit_col_ff, emit_col_in;
   logic [RW-1:0] emit_row_ff, emit_row_in;
   logic [WW-1:0] src_col_ff, src_col_in;
   logic [DW-1:0] col_rem_ff, col_rem_in;
   logic [HW-1:0] src_row_ff, src_row_in;
   logic [DW-1:0] row_rem_ff, row_rem_in;

   // response path
   logic          pend_ff, pend_in;
   logic          pend_row_end_ff, pend_row_end_in;
   logic          pend_frame_end_ff, pend_frame_end_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_pix_ff, rsp_pix_in;
   logic          rsp_row_end_ff, rsp_row_end_in;
   logic          rsp_frame_end_ff, rsp_frame_end_in;
   logic [SW-1:0] rsp_status_ff, rsp_status_in;

   // line store
   logic [PW-1:0] line_store [yyns_pkg::LINE_DEPTH];
   logic [PW-1:0] mem_rdata_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;

   logic          req_ready, accept, cfg_ok;
   logic          last_col, last_row, not_loaded, overwritten;
   logic [WW-1:0] load_next;
   logic [HW:0]   row_plus2;
   logic [DW:0]   col_sum, row_sum;
   logic          col_wrap, row_wrap;

   assign req_ready      = (state_ff == S_RUN) && !pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = req_ready;
   assign accept         = req_chan.valid && req_ready;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.pixel_pair_out = rsp_pix_ff;
   assign rsp_chan.row_end        = rsp_row_end_ff;
   assign rsp_chan.frame_end      = rsp_frame_end_ff;
   assign rsp_chan.status         = rsp_status_ff;

   assign cfg_ok = (src_w_ff >= WW'(1)) && (src_w_ff <= WW'(yyns_pkg::MAX_PAIRS)) &&
                   (dst_w_ff >= WW'(1)) && (dst_w_ff <= WW'(yyns_pkg::MAX_PAIRS)) &&
                   (src_h_ff >= HW'(2)) && (src_h_ff <= HW'(yyns_pkg::MAX_ROWS)) &&
                   (dst_h_ff >= HW'(2)) && (dst_h_ff <= HW'(yyns_pkg::MAX_ROWS));

   assign hstep = yyns_pkg::div_step(hrem_ff, hdvd_ff[DW-1], dst_h_ff);
   assign wstep = yyns_pkg::div_step(wrem_ff, wdvd_ff[DW-1], DW'(dst_w_ff));

   assign load_next = WW'(load_col_ff) + WW'(1);
   assign row_plus2 = {1'b0, src_row_ff} + (HW+1)'(2);
   assign not_loaded  = src_row_ff >= rows_done_ff;
   assign overwritten = (row_plus2 < {1'b0, rows_done_ff}) ||
                        ((row_plus2 == {1'b0, rows_done_ff}) && (load_col_ff != '0));
   assign last_col = (WW'(emit_col_ff) + WW'(1)) >= dst_w_ff;
   assign last_row = ({1'b0, emit_row_ff} + HW'(1)) >= dst_h_ff;

   // steppers: next source column / row from quotient plus remainder carry
   assign col_sum  = {1'b0, col_rem_ff} + {1'b0, wrem_ff};
   assign col_wrap = col_sum >= (DW+1)'(dst_w_ff);
   assign row_sum  = {1'b0, row_rem_ff} + {1'b0, hrem_ff};
   assign row_wrap = row_sum >= {1'b0, dst_h_ff};

   assign mem_waddr = {rows_done_ff[0], load_col_ff};
   assign mem_raddr = {src_row_ff[0], src_col_ff[CW-1:0]};

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      dst_w_in = dst_w_ff;
      dst_h_in = dst_h_ff;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      hdvd_in  = hdvd_ff;
      hrem_in  = hrem_ff;
      hquo_in  = hquo_ff;
      wdvd_in  = wdvd_ff;
      wrem_in  = wrem_ff;
      wquo_in  = wquo_ff;
      load_col_in  = load_col_ff;
      rows_done_in = rows_done_ff;
      emit_col_in  = emit_col_ff;
      emit_row_in  = emit_row_ff;
      src_col_in   = src_col_ff;
      col_rem_in   = col_rem_ff;
      src_row_in   = src_row_ff;
      row_rem_in   = row_rem_ff;
      pend_in           = 1'b0;
      pend_row_end_in   = pend_row_end_ff;
      pend_frame_end_in = pend_frame_end_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      rsp_pix_in        = rsp_pix_ff;
      rsp_row_end_in    = rsp_row_end_ff;
      rsp_frame_end_in  = rsp_frame_end_ff;
      rsp_status_in     = rsp_status_ff;
      mem_we = 1'b0;
      mem_re = 1'b0;

      unique case (state_ff)
         S_SETUP: begin
            hdvd_in  = src_h_ff;
            wdvd_in  = DW'(src_w_ff);
            hrem_in  = '0;
            wrem_in  = '0;
            hquo_in  = '0;
            wquo_in  = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            hdvd_in = {hdvd_ff[DW-2:0], 1'b0};
            wdvd_in = {wdvd_ff[DW-2:0], 1'b0};
            hrem_in = hstep.rem;
            wrem_in = wstep.rem;
            hquo_in = {hquo_ff[DW-2:0], hstep.qbit};
            wquo_in = {wquo_ff[DW-2:0], wstep.qbit};
            cnt_in  = cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == CNT_WIDTH'(DIV_STEPS - 1)) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
         end
         default: begin
            state_in = S_SETUP;
         end
      endcase

      // registered line-buffer read lands in the response register
      if (pend_ff) begin
         rsp_valid_in     = 1'b1;
         rsp_pix_in       = mem_rdata_ff;
         rsp_row_end_in   = pend_row_end_ff;
         rsp_frame_end_in = pend_frame_end_ff;
         rsp_status_in    = yyns_pkg::ST_OK;
      end

      if (accept) begin
         rsp_pix_in       = '0;
         rsp_row_end_in   = 1'b0;
         rsp_frame_end_in = 1'b0;
         rsp_status_in    = yyns_pkg::ST_OK;
         rsp_valid_in     = 1'b1;
         if (!cfg_ok) begin
            rsp_status_in = yyns_pkg::ST_BAD_CONFIG;
         end else if (req_chan.action == yyns_pkg::ACT_LOAD) begin
            if (rows_done_ff >= src_h_ff) begin
               rsp_status_in = yyns_pkg::ST_REFUSED;
            end else begin
               mem_we = 1'b1;
               if (load_next >= src_w_ff) begin
                  load_col_in  = '0;
                  rows_done_in = rows_done_ff + HW'(1);
               end else begin
                  load_col_in = load_next[CW-1:0];
               end
            end
         end else if (not_loaded) begin
            rsp_status_in = yyns_pkg::ST_NOT_LOADED;
         end else if (overwritten) begin
            rsp_status_in = yyns_pkg::ST_OVERWRITTEN;
         end else begin
            // good emit: the word goes out once the registered read data reaches the response register
            rsp_valid_in      = 1'b0;
            mem_re            = 1'b1;
            pend_in           = 1'b1;
            pend_row_end_in   = last_col;
            pend_frame_end_in = last_col && last_row;
            if (!last_col) begin
               emit_col_in = emit_col_ff + CW'(1);
               src_col_in  = src_col_ff + wquo_ff[WW-1:0] + WW'(col_wrap);
               col_rem_in  = col_wrap ? DW'(col_sum - (DW+1)'(dst_w_ff)) : col_sum[DW-1:0];
            end else begin
               emit_col_in = '0;
               src_col_in  = '0;
               col_rem_in  = '0;
               if (!last_row) begin
                  emit_row_in = emit_row_ff + RW'(1);
                  src_row_in  = src_row_ff + hquo_ff + HW'(row_wrap);
                  row_rem_in  = row_wrap ? DW'(row_sum - {1'b0, dst_h_ff}) : row_sum[DW-1:0];
               end else begin
                  emit_row_in  = '0;
                  src_row_in   = '0;
                  row_rem_in   = '0;
                  load_col_in  = '0;
                  rows_done_in = '0;
               end
            end
         end
      end

      if (csr_write_enable && (csr_index <= yyns_pkg::CSR_DST_HEIGHT)) begin
         unique case (csr_index)
            yyns_pkg::CSR_SRC_WIDTH:  src_w_in = csr_write_data[WW-1:0];
            yyns_pkg::CSR_SRC_HEIGHT: src_h_in = csr_write_data;
            yyns_pkg::CSR_DST_WIDTH:  dst_w_in = csr_write_data[WW-1:0];
            default:                  dst_h_in = csr_write_data;
         endcase
         load_col_in  = '0;
         rows_done_in = '0;
         emit_col_in  = '0;
         emit_row_in  = '0;
         src_col_in   = '0;
         col_rem_in   = '0;
         src_row_in   = '0;
         row_rem_in   = '0;
         state_in     = S_SETUP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff     <= yyns_pkg::RST_SRC_WIDTH;
         src_h_ff     <= yyns_pkg::RST_SRC_HEIGHT;
         dst_w_ff     <= yyns_pkg::RST_DST_WIDTH;
         dst_h_ff     <= yyns_pkg::RST_DST_HEIGHT;
         state_ff     <= S_SETUP;
         cnt_ff       <= '0;
         load_col_ff  <= '0;
         rows_done_ff <= '0;
         emit_col_ff  <= '0;
         emit_row_ff  <= '0;
         src_col_ff   <= '0;
         col_rem_ff   <= '0;
         src_row_ff   <= '0;
         row_rem_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         src_w_ff     <= src_w_in;
         src_h_ff     <= src_h_in;
         dst_w_ff     <= dst_w_in;
         dst_h_ff     <= dst_h_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         load_col_ff  <= load_col_in;
         rows_done_ff <= rows_done_in;
         emit_col_ff  <= emit_col_in;
         emit_row_ff  <= emit_row_in;
         src_col_ff   <= src_col_in;
         col_rem_ff   <= col_rem_in;
         src_row_ff   <= src_row_in;
         row_rem_ff   <= row_rem_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdvd_ff           <= hdvd_in;
      hrem_ff           <= hrem_in;
      hquo_ff           <= hquo_in;
      wdvd_ff           <= wdvd_in;
      wrem_ff           <= wrem_in;
      wquo_ff           <= wquo_in;
      pend_row_end_ff   <= pend_row_end_in;
      pend_frame_end_ff <= pend_frame_end_in;
      rsp_pix_ff        <= rsp_pix_in;
      rsp_row_end_ff    <= rsp_row_end_in;
      rsp_frame_end_ff  <= rsp_frame_end_in;
      rsp_status_ff     <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store[mem_waddr] <= req_chan.pixel_pair_in;
      end
      if (mem_re) begin
         mem_rdata_ff <= line_store[mem_raddr];
      end
   end

   `YYNS_ASSERT_NEXT(a_pend_fills_rsp, clock, reset, pend_ff, rsp_valid_ff, "read lost")
   `YYNS_ASSERT_SAME(a_no_accept_setup, clock, reset, state_ff != S_RUN, !req_chan.ready, "ready in setup")
   `YYNS_ASSERT_SAME(a_one_port_op, clock, reset, mem_we, !mem_re, "read and write together")
   `YYNS_ASSERT_SAME(a_read_loaded_row, clock, reset, mem_re, src_row_ff < rows_done_ff, "unloaded row read")
   `YYNS_ASSERT_NEXT(a_pend_single, clock, reset, pend_ff, !pend_ff, "pending read held")

endmodule

`default_nettype wire

// File: tb/sv/scaler_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the YUYV nearest-neighbor scaler. It watches the request, response and
// register ports, predicts every response word, and compares each field with the prediction.
// Depends on yyns_pkg and on the channel interfaces in yyns_if.

module scaler_checker (
   input  logic                                clock,
   input  logic                                reset,
   yyns_req_if                                 req_mon,
   yyns_rsp_if                                 rsp_mon,
   input  logic                                csr_write_enable,
   input  logic [yyns_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [yyns_pkg::CSR_DAT_WIDTH-1:0]  csr_write_data,
   output int                                  fail_count,
   output int                                  words_pending,
   output int                                  words_checked,
   output int                                  tally_ok,
   output int                                  tally_not_loaded,
   output int                                  tally_overwritten,
   output int                                  tally_refused,
   output int                                  tally_bad_config,
   output int                                  tally_frame_end
);
   import yyns_pkg::*;

   typedef struct packed {
      logic [PIX_WIDTH-1:0]    pixel;
      logic                    row_end;
      logic                    frame_end;
      logic [STATUS_WIDTH-1:0] status;
   } scaled_word_t;

   // shadow of the two line buffers and the scaler's position counters
   logic [PIX_WIDTH-1:0]    line_copy [LINE_DEPTH];
   logic [WIDTH_WIDTH-1:0]  src_pairs;
   logic [WIDTH_WIDTH-1:0]  dst_pairs;
   logic [HEIGHT_WIDTH-1:0] src_rows;
   logic [HEIGHT_WIDTH-1:0] dst_rows;
   int unsigned             load_col;
   int unsigned             rows_loaded;
   int unsigned             out_col;
   int unsigned             out_row;

   scaled_word_t            expected_words [$];
   int                      fails = 0;
   int                      checked = 0;
   int                      seen [5];
   int                      frame_ends = 0;

   function automatic bit config_valid();
      return src_pairs >= 1 && src_pairs <= MAX_PAIRS && dst_pairs >= 1 &&
             dst_pairs <= MAX_PAIRS && src_rows >= 2 && src_rows <= MAX_ROWS &&
             dst_rows >= 2 && dst_rows <= MAX_ROWS;
   endfunction

   function automatic void clear_positions();
      load_col    = 0;
      rows_loaded = 0;
      out_col     = 0;
      out_row     = 0;
   endfunction

   function automatic scaled_word_t scale_step(input logic act,
                                              input logic [PIX_WIDTH-1:0] pix);
      scaled_word_t res;
      int unsigned  srow;
      int unsigned  scol;
      bit           last_col;
      bit           last_row;
      res        = '0;
      res.status = ST_OK;
      if (!config_valid() || load_col >= src_pairs || rows_loaded > src_rows ||
          out_col >= dst_pairs || out_row >= dst_rows) begin
         res.status = ST_BAD_CONFIG;
         return res;
      end
      if (act == ACT_LOAD) begin
         if (rows_loaded >= src_rows) begin
            res.status = ST_REFUSED;
            return res;
         end
         // row parity picks the buffer
         line_copy[(rows_loaded % 2) * MAX_PAIRS + load_col] = pix;
         load_col++;
         if (load_col >= src_pairs) begin
            load_col = 0;
            rows_loaded++;
         end
         return res;
      end
      srow = (out_row * src_rows) / dst_rows;
      scol = (out_col * src_pairs) / dst_pairs;
      if (srow >= rows_loaded) begin
         res.status = ST_NOT_LOADED;
         return res;
      end
      // same buffer already reused by a later row
      if (srow + 2 < rows_loaded || (srow + 2 == rows_loaded && load_col > 0)) begin
         res.status = ST_OVERWRITTEN;
         return res;
      end
      last_col      = (out_col + 1 >= dst_pairs);
      last_row      = (out_row + 1 >= dst_rows);
      res.pixel     = line_copy[(srow % 2) * MAX_PAIRS + scol];
      res.row_end   = last_col;
      res.frame_end = last_col && last_row;
      if (!last_col) begin
         out_col++;
      end else if (!last_row) begin
         out_col = 0;
         out_row++;
      end else begin
         clear_positions();
      end
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      scaled_word_t want;
      bit           listed;
      if (reset) begin
         src_pairs = RST_SRC_WIDTH;
         src_rows  = RST_SRC_HEIGHT;
         dst_pairs = RST_DST_WIDTH;
         dst_rows  = RST_DST_HEIGHT;
         clear_positions();
         expected_words.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               $error("response word with no request outstanding");
               fails++;
            end else begin
               want = expected_words.pop_front();
               checked++;
               if (rsp_mon.pixel_pair_out !== want.pixel) begin
                  $error("pixel_pair_out: expected %h, got %h", want.pixel,
                         rsp_mon.pixel_pair_out);
                  fails++;
               end
               if (rsp_mon.row_end !== want.row_end) begin
                  $error("row_end: expected %b, got %b", want.row_end, rsp_mon.row_end);
                  fails++;
               end
               if (rsp_mon.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %b, got %b", want.frame_end, rsp_mon.frame_end);
                  fails++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  fails++;
               end
               if (want.status <= ST_BAD_CONFIG) begin
                  seen[want.status]++;
               end
               if (want.frame_end) begin
                  frame_ends++;
               end
            end
         end
         if (csr_write_enable) begin
            listed = 1'b1;
            case (csr_index)
               CSR_SRC_WIDTH: begin
                  src_pairs = csr_write_data[WIDTH_WIDTH-1:0];
               end
               CSR_SRC_HEIGHT: begin
                  src_rows = csr_write_data[HEIGHT_WIDTH-1:0];
               end
               CSR_DST_WIDTH: begin
                  dst_pairs = csr_write_data[WIDTH_WIDTH-1:0];
               end
               CSR_DST_HEIGHT: begin
                  dst_rows = csr_write_data[HEIGHT_WIDTH-1:0];
               end
               default: begin
                  listed = 1'b0;
               end
            endcase
            if (listed) begin
               clear_positions();
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_words.push_back(scale_step(req_mon.action, req_mon.pixel_pair_in));
         end
      end
      fail_count        <= fails;
      words_pending     <= expected_words.size();
      words_checked     <= checked;
      tally_ok          <= seen[ST_OK];
      tally_not_loaded  <= seen[ST_NOT_LOADED];
      tally_overwritten <= seen[ST_OVERWRITTEN];
      tally_refused     <= seen[ST_REFUSED];
      tally_bad_config  <= seen[ST_BAD_CONFIG];
      tally_frame_end   <= frame_ends;
   end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the scaler testbench: clock, reset, register writes, request and response
// stimulus, and the verdict. Depends on yyns_pkg, yyns_if, scaler_checker and the block.

module testbench;
   import yyns_pkg::*;

   localparam int RANDOM_WORDS = 850;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 2000;

   logic                     clock;
   logic                     reset;
   logic                     csr_write_enable;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [CSR_DAT_WIDTH-1:0] csr_write_data;

   yyns_req_if req_chan ();
   yyns_rsp_if rsp_chan ();

   int fail_count;
   int words_pending;
   int words_checked;
   int tally_ok;
   int tally_not_loaded;
   int tally_overwritten;
   int tally_refused;
   int tally_bad_config;
   int tally_frame_end;

   int idle_cycles = 0;
   bit hold_request;
   bit sender_steady = 1'b0;
   int cur_sw;
   int cur_sh;
   int cur_dw;
   int cur_dh;
   int random_words = 0;
   int settings_used = 0;

   yuyv_nearest_neighbor_scaler i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   scaler_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_chan),
      .rsp_mon           (rsp_chan),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .fail_count        (fail_count),
      .words_pending     (words_pending),
      .words_checked     (words_checked),
      .tally_ok          (tally_ok),
      .tally_not_loaded  (tally_not_loaded),
      .tally_overwritten (tally_overwritten),
      .tally_refused     (tally_refused),
      .tally_bad_config  (tally_bad_config),
      .tally_frame_end   (tally_frame_end)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // nothing moving on any port for too long means the block hung
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 15);
   endfunction

   // response side: random stalls, long open stretches, and one long hold-off on request
   initial begin : rsp_ready_driver
      int n;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request   <= 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         n = ($urandom_range(99) < 15) ? $urandom_range(120, 40) : $urandom_range(8, 1);
         rsp_chan.ready <= 1'b1;
         repeat (n) @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   // called right after a rising edge; returns at the edge where the word is taken
   task automatic send_word(input logic act, input logic [PIX_WIDTH-1:0] pix);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid         <= 1'b0;
         req_chan.pixel_pair_in <= $urandom();
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.action        <= act;
      req_chan.pixel_pair_in <= pix;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_DAT_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // width registers get a random unused top bit, which the block must drop
   task automatic apply_config(input int sw, input int sh, input int dw, input int dh,
                               input bit write_all);
      logic [CSR_DAT_WIDTH-1:0] data;
      bit                       wrote;
      drain();
      wrote = 1'b0;
      if (write_all || sw != cur_sw || $urandom_range(99) < 30) begin
         data = sw;
         data[WIDTH_WIDTH] = $urandom_range(1);
         write_reg(CSR_SRC_WIDTH, data);
         wrote = 1'b1;
      end
      if (write_all || sh != cur_sh || $urandom_range(99) < 30) begin
         write_reg(CSR_SRC_HEIGHT, sh);
         wrote = 1'b1;
      end
      if (write_all || dw != cur_dw || $urandom_range(99) < 30) begin
         data = dw;
         data[WIDTH_WIDTH] = $urandom_range(1);
         write_reg(CSR_DST_WIDTH, data);
         wrote = 1'b1;
      end
      if (write_all || dh != cur_dh || $urandom_range(99) < 30 || !wrote) begin
         write_reg(CSR_DST_HEIGHT, dh);
      end
      csr_write_enable <= 1'b0;
      cur_sw = sw;
      cur_sh = sh;
      cur_dw = dw;
      cur_dh = dh;
      settings_used++;
   endtask

   task automatic planned_word(input logic act);
      if ($urandom_range(99) < 5) begin
         send_word($urandom_range(1), $urandom());
         random_words++;
      end
      send_word(act, $urandom());
      random_words++;
   endtask

   // one destination frame in order: load each source row just before it is needed
   task automatic run_frame();
      int                       rows_in;
      int                       need;
      logic [CSR_IDX_WIDTH-1:0] spare_idx;
      rows_in = 0;
      for (int y = 0; y < cur_dh; y++) begin
         need = (y * cur_sh) / cur_dh;
         while (rows_in <= need) begin
            for (int c = 0; c < cur_sw; c++) planned_word(ACT_LOAD);
            rows_in++;
         end
         // a write to an unused index mid-frame must leave the positions alone
         if (y > 0 && $urandom_range(99) < 5) begin
            drain();
            spare_idx = CSR_DST_HEIGHT + $urandom_range(4, 1);
            write_reg(spare_idx, $urandom());
            csr_write_enable <= 1'b0;
         end
         for (int c = 0; c < cur_dw; c++) planned_word(ACT_EMIT);
      end
   endtask

   task automatic run_mix(input int count, input bit counted);
      for (int i = 0; i < count; i++) begin
         send_word($urandom_range(1), $urandom());
         if (counted) random_words++;
      end
   endtask

   initial begin : stimulus
      int roll;
      int phase;
      int sw;
      int sh;
      int dw;
      int dh;
      reset                  <= 1'b1;
      csr_write_enable       <= 1'b0;
      csr_index              <= CSR_SRC_WIDTH;
      csr_write_data         <= '0;
      req_chan.valid         <= 1'b0;
      req_chan.action        <= ACT_LOAD;
      req_chan.pixel_pair_in <= '0;
      hold_request           <= 1'b0;
      cur_sw = RST_SRC_WIDTH;
      cur_sh = RST_SRC_HEIGHT;
      cur_dw = RST_DST_WIDTH;
      cur_dh = RST_DST_HEIGHT;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // power-up sizes: nothing loaded yet
      send_word(ACT_EMIT, 32'h0000_0000);
      send_word(ACT_LOAD, 32'hA5C3_3C5A);
      send_word(ACT_EMIT, 32'hFFFF_FFFF);

      // one-pair rows, 2x vertical upscale: row reuse, refused load, frame end
      apply_config(1, 2, 2, 4, 1'b1);
      send_word(ACT_EMIT, $urandom());
      send_word(ACT_LOAD, 32'hFFFF_FFFF);
      send_word(ACT_EMIT, $urandom());
      send_word(ACT_EMIT, $urandom());
      send_word(ACT_LOAD, 32'h0000_0000);
      send_word(ACT_LOAD, 32'h1234_5678);
      repeat (6) send_word(ACT_EMIT, $urandom());

      // downscale with emits lagging: overwritten row, both with a partial and a full row ahead
      apply_config(2, 3, 1, 2, 1'b1);
      repeat (5) send_word(ACT_LOAD, $urandom());
      send_word(ACT_EMIT, $urandom());
      send_word(ACT_LOAD, $urandom());
      send_word(ACT_EMIT, $urandom());

      // source height of one row is not a legal setting
      apply_config(2, 1, 1, 2, 1'b0);
      send_word(ACT_LOAD, $urandom());
      send_word(ACT_EMIT, $urandom());

      phase = 0;
      while (random_words < RANDOM_WORDS) begin
         roll          = $urandom_range(99);
         sender_steady = ($urandom_range(99) < 20);
         if (phase == 0 || roll < 8) begin
            sw = $urandom_range(1) ? MAX_PAIRS : 1;
            sh = $urandom_range(1) ? MAX_ROWS : 2;
            dw = $urandom_range(1) ? MAX_PAIRS : 1;
            dh = $urandom_range(1) ? MAX_ROWS : 2;
            if (phase == 0) begin
               sw = MAX_PAIRS;
               sh = MAX_ROWS;
            end
            apply_config(sw, sh, dw, dh, 1'b0);
            run_mix($urandom_range(25, 10), 1'b1);
         end else if (roll < 18) begin
            sw = $urandom_range(4, 1);
            sh = $urandom_range(5, 2);
            dw = $urandom_range(6, 1);
            dh = $urandom_range(7, 2);
            case ($urandom_range(3))
               0: sw = $urandom_range(1) ? 0 : $urandom_range(4095, MAX_PAIRS + 1);
               1: sh = $urandom_range(1) ? $urandom_range(1) : $urandom_range(8191, MAX_ROWS + 1);
               2: dw = $urandom_range(1) ? 0 : $urandom_range(4095, MAX_PAIRS + 1);
               default: dh = $urandom_range(1) ? $urandom_range(1)
                                               : $urandom_range(8191, MAX_ROWS + 1);
            endcase
            apply_config(sw, sh, dw, dh, 1'b0);
            run_mix($urandom_range(8, 3), 1'b0);
         end else begin
            apply_config($urandom_range(4, 1), $urandom_range(5, 2), $urandom_range(6, 1),
                         $urandom_range(7, 2), 1'b0);
            if (phase == 2) begin
               // hold the response side so the block backs up into its input
               sender_steady = 1'b1;
               hold_request <= 1'b1;
               run_frame();
               run_frame();
            end else if (roll < 80) begin
               repeat ($urandom_range(2, 1)) run_frame();
            end else begin
               run_mix($urandom_range(30, 8), 1'b1);
            end
         end
         phase++;
      end
      drain();

      $display("Scaler run: %0d response words over %0d register settings, %0d frame ends.",
               words_checked, settings_used, tally_frame_end);
      $display("Status mix: ok %0d, not loaded %0d, overwritten %0d, refused %0d, bad config %0d.",
               tally_ok, tally_not_loaded, tally_overwritten, tally_refused, tally_bad_config);
      if (fail_count == 0 && words_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
